[rtl/core/lorentz_boost_four_vector_unit_assert.svh]
// ----------------------------------------------------------------------------
// Lorentz boost unit assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef LORENTZ_BOOST_FOUR_VECTOR_UNIT_ASSERT_SVH
`define LORENTZ_BOOST_FOUR_VECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LBF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LBF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lbf_pkg.sv]
// ----------------------------------------------------------------------------
// Lorentz boost package
// Field widths, pipeline timing, arithmetic types and field unpack helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lbf_pkg;

   localparam int SPEED_W = 31;
   localparam int DIR_W   = 32;
   localparam int MOM_W   = 32;
   localparam int OUT_W   = 48;

   localparam int DIR_LSB = SPEED_W;
   localparam int MOM_LSB = SPEED_W + 3 * DIR_W;
   localparam int ITEM_W  = MOM_LSB + 4 * MOM_W;
   localparam int REQ_W   = ((ITEM_W + 7) / 8) * 8;
   localparam int RSP_W   = 4 * OUT_W;

   // gamma unit: square, radicand, root bits, quotient bits
   localparam int ROOT_STEPS = 32;
   localparam int QUO_W      = 46;
   localparam int GAM_LAT    = 2 + ROOT_STEPS + QUO_W;

   // split multiplier
   localparam int MA_W    = 50;
   localparam int MB_W    = 35;
   localparam int MP_W    = MA_W + MB_W;
   localparam int MSPLIT  = 25;
   localparam int MUL_LAT = 2;

   // item delay taps and total latency
   localparam int TAP_M1   = GAM_LAT - 1;
   localparam int TAP_M2   = TAP_M1 + MUL_LAT;
   localparam int TAP_M3   = TAP_M2 + MUL_LAT + 1;
   localparam int DLY_LEN  = TAP_M3 + 1;
   localparam int PIPE_LAT = GAM_LAT + 3 * MUL_LAT + 4;

   typedef logic [QUO_W-1:0]       gamma_type;
   typedef logic signed [MA_W-1:0] mula_type;
   typedef logic signed [MB_W-1:0] mulb_type;
   typedef logic signed [MP_W-1:0] mulp_type;

   localparam gamma_type ONE_Q30    = gamma_type'(64'd1 << 30);
   localparam gamma_type G_BOUND    = gamma_type'((64'd1 << 45) + (64'd1 << 30));
   localparam mula_type  LAM_ONE    = mula_type'(64'd1 << 30);
   localparam mulp_type  ROUND_HALF = mulp_type'(64'd1 << 29);

   function automatic logic signed [DIR_W-1:0] dir_of(input logic [ITEM_W-1:0] item,
                                                      input int idx);
      dir_of = $signed(item[DIR_LSB + idx * DIR_W +: DIR_W]);
   endfunction

   function automatic logic signed [MOM_W-1:0] mom_of(input logic [ITEM_W-1:0] item,
                                                      input int idx);
      mom_of = $signed(item[MOM_LSB + idx * MOM_W +: MOM_W]);
   endfunction

endpackage

`default_nettype wire

[rtl/core/lbf_mul.sv]
// ----------------------------------------------------------------------------
// Split signed multiplier
// 50x35 signed product from two narrower partial products, two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lbf_mul (
   input  logic              clock,
   input  logic              en,
   input  lbf_pkg::mula_type a,
   input  lbf_pkg::mulb_type b,
   output lbf_pkg::mulp_type p
);
   import lbf_pkg::*;

   logic signed [MSPLIT:0]             a_lo;
   logic signed [MA_W-MSPLIT-1:0]      a_hi;
   logic signed [MSPLIT+MB_W:0]        lo_ff;
   logic signed [MA_W-MSPLIT+MB_W-1:0] hi_ff;
   mulp_type                           p_ff;

   assign a_lo = $signed({1'b0, a[MSPLIT-1:0]});
   assign a_hi = $signed(a[MA_W-1:MSPLIT]);

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= a_lo * b;
         hi_ff <= a_hi * b;
         p_ff  <= (MP_W'(hi_ff) <<< MSPLIT) + MP_W'(lo_ff);
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

[rtl/core/lbf_gamma.sv]
// ----------------------------------------------------------------------------
// Gamma unit
// gamma = 2^61 / isqrt(2^62 - speed^2); one root bit, then one quotient
// bit, per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbf_gamma (
   input  logic                       clock,
   input  logic                       en,
   input  logic [lbf_pkg::SPEED_W-1:0] speed,
   output lbf_pkg::gamma_type          gamma
);
   import lbf_pkg::*;

   logic [61:0] sq_ff;
   logic [62:0] rad_ff;
   logic [62:0] rem_ff  [ROOT_STEPS];
   logic [63:0] root_ff [ROOT_STEPS];
   logic [31:0] drem_ff [QUO_W];
   logic [31:0] dvs_ff  [QUO_W];
   gamma_type   quo_ff  [QUO_W];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= speed * speed;
         rad_ff <= (63'd1 << 62) - {1'b0, sq_ff};
      end
   end

   genvar k;
   for (k = 0; k < ROOT_STEPS; k++) begin : g_root
      logic [62:0] rem_prev;
      logic [63:0] root_prev;
      logic [63:0] bitv;
      logic [63:0] trial;
      logic [62:0] rem_in;
      logic [63:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = rad_ff;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign bitv  = 64'd1 << (62 - 2 * k);
      assign trial = root_prev + bitv;

      always_comb begin
         if ({1'b0, rem_prev} >= trial) begin
            rem_in  = 63'({1'b0, rem_prev} - trial);
            root_in = (root_prev >> 1) + bitv;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   // dividend 2^61: the bits above the quotient leave a remainder of 2^15
   genvar j;
   for (j = 0; j < QUO_W; j++) begin : g_div
      logic [31:0] drem_prev;
      logic [31:0] dvs_prev;
      gamma_type   quo_prev;
      logic [32:0] shifted;
      logic        take;

      if (j == 0) begin : g_first
         assign drem_prev = 32'h0000_8000;
         assign dvs_prev  = root_ff[ROOT_STEPS-1][31:0];
         assign quo_prev  = '0;
      end else begin : g_next
         assign drem_prev = drem_ff[j-1];
         assign dvs_prev  = dvs_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
      end

      assign shifted = {drem_prev, 1'b0};
      assign take    = shifted >= {1'b0, dvs_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[j] <= take ? 32'(shifted - {1'b0, dvs_prev}) : shifted[31:0];
            dvs_ff[j]  <= dvs_prev;
            quo_ff[j]  <= {quo_prev[QUO_W-2:0], take};
         end
      end
   end

   assign gamma = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

[rtl/core/lorentz_boost_four_vector_unit.sv]
// ----------------------------------------------------------------------------
// Lorentz boost four-vector unit
// Boosts a Q16.16 four-vector by speed beta along direction n; Q32.16
// saturated result.
// ----------------------------------------------------------------------------
//
//   channel   dir   fields (tdata, low bit first)
//   req_      in    speed, dir_x, dir_y, dir_z, mom_t, mom_x, mom_y, mom_z
//   rsp_      out   out_t, out_x, out_y, out_z
//
// One transfer per cycle while the output is not stalled. Items pass the
// gamma unit (a square stage, a radicand stage, 32 square-root stages and
// 46 divide stages), three split multiplies, a matrix register and a
// three-stage sum and saturate.
// The whole pipeline advances when the output is empty or taken; a stall
// freezes every stage, so nothing is lost or repeated.
// Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lorentz_boost_four_vector_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // speed[30:0] dir_x[62:31] dir_y[94:63] dir_z[126:95] mom_t[158:127]
   // mom_x[190:159] mom_y[222:191] mom_z[254:223] pad[255]
   input  logic [lbf_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // out_t[47:0] out_x[95:48] out_y[143:96] out_z[191:144]
   output logic [lbf_pkg::RSP_W-1:0]  rsp_tdata
);
   import lbf_pkg::*;

`include "lorentz_boost_four_vector_unit_assert.svh"

   // global advance: last stage empty or its transfer completes
   logic                en;
   logic [PIPE_LAT-1:0] valid_ff;
   logic [PIPE_LAT-1:0] valid_in;

   assign en         = !valid_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[PIPE_LAT-1];
   assign valid_in   = {valid_ff[PIPE_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // item delay line; direction and momentum are tapped where needed
   logic [ITEM_W-1:0] item_ff [DLY_LEN];

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= req_tdata[ITEM_W-1:0];
         for (int i = 1; i < DLY_LEN; i++) begin
            item_ff[i] <= item_ff[i-1];
         end
      end
   end

   // gamma in Q.30
   gamma_type g;

   lbf_gamma u_gamma (
      .clock (clock),
      .en    (en),
      .speed (req_tdata[SPEED_W-1:0]),
      .gamma (g)
   );

   // gamma and gamma - 1 ride alongside the first two multiply rounds
   gamma_type g_ff   [4];
   gamma_type gm1_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff[0]   <= g;
         g_ff[1]   <= g_ff[0];
         g_ff[2]   <= g_ff[1];
         g_ff[3]   <= g_ff[2];
         gm1_ff[0] <= g - ONE_Q30;
         gm1_ff[1] <= gm1_ff[0];
      end
   end

   // round 1: beta*gamma and n_i*n_j
   mulp_type bgp;
   mulp_type nnp [3][3];

   lbf_mul u_bg (
      .clock (clock),
      .en    (en),
      .a     (mula_type'({{(MA_W-QUO_W){1'b0}}, g})),
      .b     (mulb_type'({{(MB_W-SPEED_W){1'b0}}, item_ff[TAP_M1][SPEED_W-1:0]})),
      .p     (bgp)
   );

   // round 2: bg*n_i and (gamma-1)*nn_ij
   mulp_type cp [3];
   mulp_type lp [3][3];

   genvar i, j;
   for (i = 0; i < 3; i++) begin : g_row
      lbf_mul u_c (
         .clock (clock),
         .en    (en),
         .a     (mula_type'(bgp[MA_W+30:31])),
         .b     (mulb_type'(dir_of(item_ff[TAP_M2], i))),
         .p     (cp[i])
      );
      for (j = 0; j < 3; j++) begin : g_col
         lbf_mul u_nn (
            .clock (clock),
            .en    (en),
            .a     (mula_type'(dir_of(item_ff[TAP_M1], i))),
            .b     (mulb_type'(dir_of(item_ff[TAP_M1], j))),
            .p     (nnp[i][j])
         );
         lbf_mul u_l (
            .clock (clock),
            .en    (en),
            .a     (mula_type'({{(MA_W-QUO_W){1'b0}}, gm1_ff[1]})),
            .b     (mulb_type'(nnp[i][j][MB_W+29:30])),
            .p     (lp[i][j])
         );
      end
   end

   // boost matrix register
   mula_type lam_ff [4][4];
   mula_type lam_in [4][4];

   always_comb begin
      lam_in[0][0] = mula_type'({{(MA_W-QUO_W){1'b0}}, g_ff[3]});
      for (int r = 0; r < 3; r++) begin
         lam_in[0][r+1] = -mula_type'(cp[r][MA_W+29:30]);
         lam_in[r+1][0] = -mula_type'(cp[r][MA_W+29:30]);
         for (int c = 0; c < 3; c++) begin
            lam_in[r+1][c+1] = mula_type'(lp[r][c][MA_W+29:30])
                               + ((r == c) ? LAM_ONE : mula_type'(0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lam_ff <= lam_in;
      end
   end

   // round 3: matrix times four-vector
   mulp_type tp [4][4];

   for (i = 0; i < 4; i++) begin : g_mrow
      for (j = 0; j < 4; j++) begin : g_mcol
         lbf_mul u_t (
            .clock (clock),
            .en    (en),
            .a     (lam_ff[i][j]),
            .b     (mulb_type'(mom_of(item_ff[TAP_M3], j))),
            .p     (tp[i][j])
         );
      end
   end

   // sum in two stages (round half in), then shift and saturate
   mulp_type             half_ff [4][2];
   mulp_type             acc_ff  [4];
   logic [OUT_W-1:0]     out_ff  [4];
   logic [OUT_W-1:0]     out_in  [4];
   logic [MP_W-OUT_W-30:0] upper [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         upper[r] = acc_ff[r][MP_W-1:OUT_W+29];
         if ((&upper[r]) || !(|upper[r])) begin
            out_in[r] = acc_ff[r][OUT_W+29:30];
         end else if (acc_ff[r][MP_W-1]) begin
            out_in[r] = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            out_in[r] = {1'b0, {(OUT_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            half_ff[r][0] <= tp[r][0] + tp[r][1];
            half_ff[r][1] <= tp[r][2] + tp[r][3] + ROUND_HALF;
            acc_ff[r]     <= half_ff[r][0] + half_ff[r][1];
            out_ff[r]     <= out_in[r];
         end
      end
   end

   assign rsp_tdata = {out_ff[3], out_ff[2], out_ff[1], out_ff[0]};

   // gamma must lie between one and the bound set by the smallest root
   `LBF_ASSERT_IMPL(a_gamma_range, valid_ff[TAP_M1], (g >= ONE_Q30) && (g <= G_BOUND), "gamma out of range")
   // an item in the stage before the output reaches it on an advance
   `LBF_ASSERT_NEXT(a_last_advance, en && valid_ff[PIPE_LAT-2], rsp_tvalid, "item dropped before output")
   // a stall freezes the whole valid chain
   `LBF_ASSERT_NEXT(a_stall_freeze, !en, $stable(valid_ff), "pipeline moved during stall")

endmodule

`default_nettype wire

[tb/lorentz_boost_four_vector_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lorentz boost four-vector unit testbench
// Streams directed and random boost requests through the unit with random
// bursts, gaps and output stalls, and checks each result against an
// in-bench fixed-point predictor of the boosted four-vector.
// ----------------------------------------------------------------------------
`default_nettype none

module lorentz_boost_four_vector_unit_tb;
   import lbf_pkg::*;

   localparam int N_RANDOM   = 1700;
   localparam int IDLE_LIMIT = 3000;   // cycles with no transfer at all
   localparam int HOLD_START = 600;    // receiver long hold-off window
   localparam int HOLD_LEN   = 500;

   // packed high field first, so speed lands in the low bits
   typedef struct packed {
      logic signed [MOM_W-1:0] mom_z, mom_y, mom_x, mom_t;
      logic signed [DIR_W-1:0] dir_z, dir_y, dir_x;
      logic [SPEED_W-1:0]      speed;
   } boost_req_type;

   // one queued entry: either a request or a "wait until drained" marker
   typedef struct {
      bit            drain;
      boost_req_type req;
   } feed_entry_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;   // speed, dir_x..z, mom_t..z, pad (low bit first)
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;   // out_t, out_x, out_y, out_z (low bit first)

   feed_entry_type    feed_q[$];
   logic [RSP_W-1:0]  boosted_q[$];
   int                mismatches;
   int                burst_left;
   int                gap_left;
   int                rx_cycle;
   int                idle_cycles;

   lorentz_boost_four_vector_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------------
   // Predictor: gamma by integer root and divide, boost matrix, then the
   // rounded matrix-vector product clamped to 48 bits. Shifts floor.
   // ---------------------------------------------------------------------------
   function automatic logic [63:0] int_sqrt(input logic [63:0] val);
      logic [63:0] root, bit_w, rem;
      rem   = val;
      root  = '0;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem  = rem - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // signed 128-bit product, floor shift, keep low 64 bits
   function automatic logic signed [63:0] mul_shr(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input int sh);
      logic signed [127:0] prod;
      prod = 128'(a) * 128'(b);
      prod = prod >>> sh;
      return prod[63:0];
   endfunction

   function automatic logic [RSP_W-1:0] boost_vector(input boost_req_type r);
      logic [63:0]         rad, root;
      logic signed [63:0]  gam, bgam;
      logic signed [63:0]  dir[3];
      logic signed [63:0]  mom[4];
      logic signed [63:0]  mat[4][4];
      logic signed [127:0] acc;
      logic [RSP_W-1:0]    res;
      dir[0] = r.dir_x; dir[1] = r.dir_y; dir[2] = r.dir_z;
      mom[0] = r.mom_t; mom[1] = r.mom_x; mom[2] = r.mom_y; mom[3] = r.mom_z;
      rad  = (64'd1 << 62) - 64'(r.speed) * 64'(r.speed);
      root = int_sqrt(rad);
      gam  = (64'd1 << 61) / root;
      bgam = mul_shr($signed({33'd0, r.speed}), gam, 31);
      mat[0][0] = gam;
      for (int i = 1; i <= 3; i++) begin
         mat[0][i] = -mul_shr(bgam, dir[i-1], 30);
         mat[i][0] = mat[0][i];
         for (int j = 1; j <= 3; j++)
            mat[i][j] = mul_shr(gam - (64'sd1 <<< 30),
                                mul_shr(dir[i-1], dir[j-1], 30), 30);
         mat[i][i] = mat[i][i] + (64'sd1 <<< 30);
      end
      for (int i = 0; i < 4; i++) begin
         acc = 128'sd1 <<< 29;
         for (int j = 0; j < 4; j++)
            acc = acc + 128'(mat[i][j]) * 128'(mom[j]);
         acc = acc >>> 30;
         if (acc > 128'sd140737488355327)       acc = 128'sd140737488355327;
         else if (acc < -128'sd140737488355328) acc = -128'sd140737488355328;
         res[i*OUT_W +: OUT_W] = acc[OUT_W-1:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: bursts of random length, random gaps. A drain marker holds the
   // sender until every expected result has come back.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      feed_entry_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= 1;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            boosted_q.push_back(boost_vector(boost_req_type'(req_tdata[ITEM_W-1:0])));
         if (req_tvalid && !req_tready) begin
            // hold the current transfer
         end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (feed_q.size() != 0 && feed_q[0].drain) begin
            req_tvalid <= 1'b0;
            if (boosted_q.size() == 0) void'(feed_q.pop_front());
         end else if (feed_q.size() != 0) begin
            head       = feed_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_W-ITEM_W){1'b0}}, head.req};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               // some stretches run back to back
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver stall pattern: four modes taken in turn from rx_cycle, plus one
   // long hold-off so the pipeline fills and back-pressures the input.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle   <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
            rsp_tready <= 1'b0;
         else
            case ((rx_cycle >> 8) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (boosted_q.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected result transfer: %h", rsp_tdata);
         end else begin
            want = boosted_q.pop_front();
            for (int f = 0; f < 4; f++)
               if (want[f*OUT_W +: OUT_W] !== rsp_tdata[f*OUT_W +: OUT_W]) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("component %0d: expected %h, got %h", f,
                              want[f*OUT_W +: OUT_W], rsp_tdata[f*OUT_W +: OUT_W]);
               end
         end
      end
   end

   // watchdog: too long with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   function automatic logic signed [31:0] rand_dir();
      case ($urandom_range(0, 5))
         0: return 32'sd1073741824;
         1: return -32'sd1073741824;
         2: return 32'sd0;
         3: return $signed($urandom());                      // off unit length
         default: return $signed(32'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_mom();
      case ($urandom_range(0, 3))
         0: return $signed($urandom());
         1: return $signed(32'($urandom_range(0, 32'h1ffff)) - 32'sh10000);
         2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $signed(32'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      endcase
   endfunction

   function automatic logic [SPEED_W-1:0] rand_speed();
      case ($urandom_range(0, 4))
         0: return 31'h7fff_ffff - 31'($urandom_range(0, 4095));   // near one
         1: return 31'($urandom_range(0, 4095));                   // near zero
         default: return 31'($urandom());
      endcase
   endfunction

   task automatic add_req(input logic [SPEED_W-1:0] spd,
                          input logic signed [31:0] nx, ny, nz,
                          input logic signed [31:0] pt, px, py, pz);
      feed_entry_type e;
      e.drain = 1'b0;
      e.req   = '{speed: spd, dir_x: nx, dir_y: ny, dir_z: nz,
                  mom_t: pt, mom_x: px, mom_y: py, mom_z: pz};
      feed_q.push_back(e);
   endtask

   task automatic add_drain();
      feed_entry_type e;
      e.drain = 1'b1;
      e.req   = '0;
      feed_q.push_back(e);
   endtask

   localparam logic signed [31:0] UNIT = 32'sd1073741824;
   localparam logic signed [31:0] MAXM = 32'sh7fff_ffff;
   localparam logic signed [31:0] MINM = 32'sh8000_0000;

   initial begin
      mismatches  = 0;
      idle_cycles = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;

      // directed: rest frame, each axis, speed extremes, saturation, odd dirs
      add_req(31'd0, UNIT, 0, 0, 32'sh10000, 32'sh20000, 0, 0);
      add_req(31'h4000_0000, UNIT, 0, 0, 32'sh10000, 0, 0, 0);
      add_req(31'h4000_0000, 0, UNIT, 0, 32'sh10000, 0, 32'sh8000, 0);
      add_req(31'h4000_0000, 0, 0, UNIT, 32'sh10000, 0, 0, -32'sh8000);
      add_req(31'h4000_0000, -UNIT, 0, 0, 32'sh30000, 32'sh10000, 0, 0);
      add_req(31'h7fff_ffff, UNIT, 0, 0, 32'sh10000, 0, 0, 0);
      add_req(31'h7fff_ffff, UNIT, 0, 0, MAXM, MINM, 0, 0);
      add_req(31'h7fff_ffff, -UNIT, 0, 0, MAXM, MAXM, MAXM, MAXM);
      add_req(31'h7fff_ffff, UNIT, UNIT, UNIT, MINM, MINM, MINM, MINM);
      add_req(31'h7fff_ffff, MAXM, MINM, MAXM, MAXM, MINM, MAXM, MINM);
      add_req(31'h7fff_ffff, MINM, MINM, MINM, MAXM, MAXM, MAXM, MAXM);
      add_req(31'h0000_0001, MAXM, MAXM, MAXM, MINM, MAXM, MINM, MAXM);
      add_req(31'h5555_5555, 32'sh2000_0000, 32'sh2000_0000, 32'sh2d41_3ccd,
              32'sh0001_8000, -32'sh0001_0000, 32'sh0000_4000, 32'sh7fff_0000);
      add_req(31'h2aaa_aaaa, 0, 0, 0, MAXM, MINM, 32'sh1234_5678, -32'sh1);
      add_req(31'h7ff0_0000, 32'sh2d41_3ccd, -32'sh2d41_3ccd, 0, MAXM, 0, 0, 0);
      add_req(31'h7fff_0000, 0, -UNIT, 0, 32'sh7fff_ffff, 32'sh0, 32'sh7fff_ffff, 0);
      add_req(31'd0, 0, 0, 0, 0, 0, 0, 0);
      add_req(31'h6000_0000, UNIT, 0, 0, -32'sh1, -32'sh1, -32'sh1, -32'sh1);
      add_drain();   // sender waits for the pipeline to empty

      for (int k = 0; k < N_RANDOM; k++) begin
         add_req(rand_speed(), rand_dir(), rand_dir(), rand_dir(),
                 rand_mom(), rand_mom(), rand_mom(), rand_mom());
         if (k == N_RANDOM / 2) add_drain();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait for the last request, then for every result
      do @(posedge clock);
      while (feed_q.size() != 0 || req_tvalid || boosted_q.size() != 0);
      repeat (PIPE_LAT + 20) @(posedge clock);

      if (mismatches == 0 && boosted_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
